FILE: hw/rtl/icon_tile_slot_cache_core_assert.svh
// assertion macros for the icon tile slot cache checker
`ifndef ICON_TILE_SLOT_CACHE_CORE_ASSERT_SVH
`define ICON_TILE_SLOT_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define ITSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icon tile slot cache assertion failed");

// next-cycle implication
`define ITSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icon tile slot cache assertion failed");

`endif

FILE: hw/rtl/itsc_pkg.sv
// shared types and constants for the icon tile slot cache
`default_nettype none

package itsc_pkg;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        logic none;
        logic placed;
    } flags_t;

    localparam int         TILE_SHIFT     = 2;
    localparam int         CHUNK_W        = 8;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [5:0] ACTIVE_MAX     = 6'd63;
    localparam logic [9:0] TOP_TILE_RESET = 10'd1023;

endpackage

`default_nettype wire

FILE: hw/rtl/itsc_alu.sv
// shared 16-bit add/subtract unit for tile base and attribute sums
`default_nettype none

module itsc_alu
    import itsc_pkg::*;
(
    input  wire alu_op_t     op,
    input  wire logic [15:0] a,
    input  wire logic [15:0] b,
    output logic      [15:0] y
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/icon_tile_slot_cache_core.sv
// top level of the icon tile slot cache: slot table, free-slot scan, shared adder
//
// channel  | dir | handshake                  | content
// s_       | in  | s_tvalid / s_tready        | request: tuser req_type, tdata icon, tile_attr
// m_       | out | m_tvalid / m_tready        | result: tdata tile, active_count, tuser flags
// cfg_     | in  | cfg_valid / cfg_ready      | top_tile write
//
// release or blank request: from accept through ST_READ and ST_FINISH to the result register
// get of a placed icon: ST_READ, ST_ADD1, ST_ADD2, ST_FINISH; a new placement also passes
// through ST_SEARCH, the 8-bit-per-cycle free-slot scan, then through the shared adder twice
// after reset the icon table is cleared, one entry a cycle, all ICON_COUNT entries, s_tready low
// a held result stalls only the final write-back step
`default_nettype none

module icon_tile_slot_cache_core
    import itsc_pkg::*;
#(
    parameter int ICON_COUNT = 256,
    parameter int SLOT_COUNT = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // icon[8:0], tile_attr[24:9], zero pad
    input  wire logic [0:0]  s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // tile[15:0], active_count[21:16], zero pad
    output logic      [1:0]  m_tuser,   // newly_placed[0], no_slot[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);

    localparam int IW   = (ICON_COUNT > 1) ? $clog2(ICON_COUNT) : 1;
    localparam int SW   = $clog2(SLOT_COUNT + 1);
    localparam int AW   = $clog2(SLOT_COUNT + 1);
    localparam int NCH  = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * CHUNK_W;
    localparam int MW   = 8 + SW;

    localparam logic [IW-1:0] LAST_ICON  = IW'(ICON_COUNT - 1);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(NCH - 1);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_ADD1,
        ST_ADD2,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [MW-1:0] mem_array [ICON_COUNT];
    logic [MW-1:0] rd_word_reg;

    logic [IW-1:0]         clr_reg, clr_next;
    logic [9:0]            top_reg, top_next;
    logic [SLOT_COUNT-1:0] occ_reg, occ_next;
    logic [AW-1:0]         active_reg, active_next;
    logic [CW-1:0]         ch_reg, ch_next;

    logic          req_reg, req_next;
    logic          valid_reg, valid_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   attr_reg, attr_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [15:0]   acc_reg, acc_next;
    logic          wr_reg, wr_next;
    flags_t        flags_reg, flags_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] tile_out_reg, tile_out_next;
    logic [5:0]  act_out_reg, act_out_next;
    flags_t      flags_out_reg, flags_out_next;

    logic          in_fire;
    logic [8:0]    in_icon;
    logic [31:0]   in_icon_ext;
    logic [IW-1:0] in_idx;
    logic          in_valid;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [7:0]    rd_cnt;
    logic [SW-1:0] rd_slot;

    logic [PADW-1:0]    free_pad;
    logic [CHUNK_W-1:0] chunk;
    logic               chunk_found;
    int                 chunk_pos;
    logic [SW-1:0]      found_s1;

    alu_op_t     alu_op;
    logic [15:0] alu_a;
    logic [15:0] alu_b;
    logic [15:0] alu_y;

    itsc_alu u_alu
    (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign in_fire     = s_tvalid && s_tready;
    assign in_icon     = s_tdata[8:0];
    assign in_icon_ext = 32'(in_icon[7:0]);
    assign in_idx      = in_icon_ext[IW-1:0];
    assign in_valid    = !in_icon[8] && (in_icon_ext < 32'(ICON_COUNT));

    assign rd_cnt  = rd_word_reg[MW-1:SW];
    assign rd_slot = rd_word_reg[SW-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, act_out_reg, tile_out_reg};
    assign m_tuser  = {flags_out_reg.none, flags_out_reg.placed};

    // lowest free slot within the current 8-slot chunk
    always_comb
    begin
        free_pad                 = '0;
        free_pad[SLOT_COUNT-1:0] = ~occ_reg;
        chunk                    = free_pad[ch_reg * CHUNK_W +: CHUNK_W];
        chunk_found              = 1'b0;
        chunk_pos                = 0;
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            if (chunk[j])
            begin
                chunk_found = 1'b1;
                chunk_pos   = j;
            end
        end
        found_s1 = SW'(32'(ch_reg) * CHUNK_W + chunk_pos + 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        top_next       = top_reg;
        occ_next       = occ_reg;
        active_next    = active_reg;
        ch_next        = ch_reg;
        req_next       = req_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        attr_next      = attr_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        acc_next       = acc_reg;
        wr_next        = wr_reg;
        flags_next     = flags_reg;
        m_tvalid_next  = m_tvalid_reg;
        tile_out_next  = tile_out_reg;
        act_out_next   = act_out_reg;
        flags_out_next = flags_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = {cnt_reg, slot_reg};
        alu_op         = ALU_ADD;
        alu_a          = acc_reg;
        alu_b          = attr_reg;

        if (cfg_valid && cfg_ready)
        begin
            top_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_ICON)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next   = s_tuser[0];
                    valid_next = in_valid;
                    idx_next   = in_idx;
                    attr_next  = s_tdata[24:9];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_next   = rd_cnt;
                slot_next  = rd_slot;
                acc_next   = '0;
                wr_next    = 1'b0;
                flags_next = '0;
                if (!valid_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (req_reg)
                begin
                    slot_next = '0;
                    wr_next   = 1'b1;
                    if (rd_slot != '0)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (SW'(i + 1) == rd_slot)
                            begin
                                occ_next[i] = 1'b0;
                            end
                        end
                        active_next = active_reg - AW'(1);
                    end
                    state_next = ST_FINISH;
                end
                else if (rd_slot != '0)
                begin
                    wr_next = 1'b1;
                    if (rd_cnt != COUNT_MAX)
                    begin
                        cnt_next = rd_cnt + 8'd1;
                    end
                    state_next = ST_ADD1;
                end
                else
                begin
                    wr_next    = 1'b1;
                    cnt_next   = rd_cnt + 8'd1;
                    ch_next    = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chunk_found)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (SW'(i + 1) == found_s1)
                        begin
                            occ_next[i] = 1'b1;
                        end
                    end
                    active_next       = active_reg + AW'(1);
                    slot_next         = found_s1;
                    flags_next.placed = 1'b1;
                    state_next        = ST_ADD1;
                end
                else if (ch_reg == LAST_CHUNK)
                begin
                    flags_next.none = 1'b1;
                    state_next      = ST_ADD1;
                end
                else
                begin
                    ch_next = ch_reg + CW'(1);
                end
            end
            ST_ADD1:
            begin
                alu_op     = ALU_SUB;
                alu_a      = 16'(top_reg);
                alu_b      = 16'(slot_reg) << TILE_SHIFT;
                acc_next   = alu_y;
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                alu_op     = ALU_ADD;
                alu_a      = acc_reg;
                alu_b      = attr_reg;
                acc_next   = alu_y;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    tile_out_next  = acc_reg;
                    flags_out_next = flags_reg;
                    if (32'(active_reg) > 32'(ACTIVE_MAX))
                    begin
                        act_out_next = ACTIVE_MAX;
                    end
                    else
                    begin
                        act_out_next = 6'(active_reg);
                    end
                    mem_we     = wr_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            top_reg      <= TOP_TILE_RESET;
            occ_reg      <= '0;
            active_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            top_reg      <= top_next;
            occ_reg      <= occ_next;
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        req_reg       <= req_next;
        valid_reg     <= valid_next;
        idx_reg       <= idx_next;
        attr_reg      <= attr_next;
        cnt_reg       <= cnt_next;
        slot_reg      <= slot_next;
        acc_reg       <= acc_next;
        wr_reg        <= wr_next;
        flags_reg     <= flags_next;
        tile_out_reg  <= tile_out_next;
        act_out_reg   <= act_out_next;
        flags_out_reg <= flags_out_next;
    end

    // icon table: use count over slot number
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_word_reg <= mem_array[in_idx];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/itsc_checker.sv
// port-level checks for the icon tile slot cache, bound to the top level
`default_nettype none

`include "icon_tile_slot_cache_core_assert.svh"

module itsc_checker
#(
    parameter int SLOT_COUNT = 32
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result stays offered
    `ITSC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // one request at a time
    `ITSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // occupied count never exceeds the pool
    `ITSC_ASSERT_NOW(a_active_bound, clk, rst_n, m_tvalid, 32'(m_tdata[21:16]) <= SLOT_COUNT)

    // a placement and a full pool cannot be reported together
    `ITSC_ASSERT_NOW(a_flags_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))

endmodule

bind icon_tile_slot_cache_core itsc_checker #(.SLOT_COUNT(SLOT_COUNT)) u_itsc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire
